@@ hdl/tod_pkg.sv @@
// ----------------------------------------------------------------------------
// tod_pkg - time-of-day clock shared definitions
// Operation and mode codes, day constants and the word passed from the
// step-count split pipeline to the clock core.
// ----------------------------------------------------------------------------
package tod_pkg;

	// operation codes
	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_ADVANCE = 2'd1;
	localparam logic [1:0] FUNC_RETREAT = 2'd2;
	localparam logic [1:0] FUNC_CONVERT = 2'd3;

	// mode codes
	localparam logic [1:0] MODE_24 = 2'd0;
	localparam logic [1:0] MODE_AM = 2'd1;
	localparam logic [1:0] MODE_PM = 2'd2;

	localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
	localparam logic [5:0]  MAX_MIN_SEC   = 6'd59;
	localparam logic [4:0]  MAX_HOUR24    = 5'd23;
	localparam logic [4:0]  LAST_AM_HOUR  = 5'd11;
	localparam logic [4:0]  HALF_DAY      = 5'd12;
	localparam logic [4:0]  FIRST_PM_HOUR = 5'd13;
	localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
	localparam logic [6:0]  SIXTY         = 7'd60;

	// floor(x / 3600) = (x * RECIP_3600) >> 27 and floor(x / 60) = (x * RECIP_60) >> 23,
	// exact for x below one day
	localparam logic [15:0] RECIP_3600 = 16'd37283;
	localparam logic [17:0] RECIP_60   = 18'd139811;

	typedef struct packed {
		logic [1:0] func;
		logic [4:0] load_hour;
		logic [5:0] load_minute;
		logic [5:0] load_second;
		logic [1:0] load_mode;
		logic [4:0] step_hour;
		logic [5:0] step_minute;
		logic [5:0] step_second;
	} split_item_t;

endpackage

@@ hdl/tod_in_if.sv @@
// ----------------------------------------------------------------------------
// tod_in_if - command channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface tod_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [4:0]  load_hour;
	logic [5:0]  load_minute;
	logic [5:0]  load_second;
	logic [1:0]  load_mode;
	logic [16:0] step_count;

	modport source (output valid, func, load_hour, load_minute, load_second, load_mode,
		step_count, input ready);
	modport sink (input valid, func, load_hour, load_minute, load_second, load_mode,
		step_count, output ready);
endinterface

@@ hdl/tod_out_if.sv @@
// ----------------------------------------------------------------------------
// tod_out_if - result channel
// Valid/ready channel carrying the time after each operation.
// ----------------------------------------------------------------------------
interface tod_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] cur_hour;
	logic [5:0] cur_minute;
	logic [5:0] cur_second;
	logic [1:0] cur_mode;
	logic       rejected;

	modport source (output valid, cur_hour, cur_minute, cur_second, cur_mode, rejected,
		input ready);
	modport sink (input valid, cur_hour, cur_minute, cur_second, cur_mode, rejected,
		output ready);
endinterface

@@ hdl/tod_split.sv @@
// ----------------------------------------------------------------------------
// tod_split - step count split
// Registers the command word, reduces the count modulo one day and splits it
// into hours, minutes and seconds over three stages.
// ----------------------------------------------------------------------------
module tod_split
	import tod_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	tod_in_if.sink      cmd,
	output split_item_t item,
	output logic        item_valid
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [1:0]  func_s1, func_s2, func_s3;
	logic [4:0]  lh_s1, lh_s2, lh_s3;
	logic [5:0]  lm_s1, lm_s2, lm_s3;
	logic [5:0]  ls_s1, ls_s2, ls_s3;
	logic [1:0]  lmode_s1, lmode_s2, lmode_s3;
	logic [16:0] cnt_s1;
	logic [16:0] delta_s2, delta_s3;
	logic [4:0]  dh_s3;
	logic [10:0] mtot_s3;
	split_item_t item_s4;

	logic [16:0] delta;
	logic [32:0] prod_h;
	logic [34:0] prod_m;
	logic [10:0] hour_sec_min;
	logic [16:0] min_sec;
	logic [10:0] dm_full;
	logic [16:0] ds_full;

	assign cmd.ready = en;

	// count is below two days, one subtract brings it into the day
	assign delta = (cnt_s1 >= SEC_PER_DAY) ? (cnt_s1 - SEC_PER_DAY) : cnt_s1;

	assign prod_h = 33'(delta_s2) * 33'(RECIP_3600);
	assign prod_m = 35'(delta_s2) * 35'(RECIP_60);

	// dh*60 and mtot*60 as shift-and-subtract
	assign hour_sec_min = {dh_s3, 6'd0} - {4'd0, dh_s3, 2'd0};
	assign min_sec      = {mtot_s3, 6'd0} - {4'd0, mtot_s3, 2'd0};
	assign dm_full      = mtot_s3 - hour_sec_min;
	assign ds_full      = delta_s3 - min_sec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= cmd.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1  <= cmd.func;
			lh_s1    <= cmd.load_hour;
			lm_s1    <= cmd.load_minute;
			ls_s1    <= cmd.load_second;
			lmode_s1 <= cmd.load_mode;
			cnt_s1   <= cmd.step_count;

			func_s2  <= func_s1;
			lh_s2    <= lh_s1;
			lm_s2    <= lm_s1;
			ls_s2    <= ls_s1;
			lmode_s2 <= lmode_s1;
			delta_s2 <= delta;

			func_s3  <= func_s2;
			lh_s3    <= lh_s2;
			lm_s3    <= lm_s2;
			ls_s3    <= ls_s2;
			lmode_s3 <= lmode_s2;
			delta_s3 <= delta_s2;
			dh_s3    <= prod_h[31:27];
			mtot_s3  <= prod_m[33:23];

			item_s4.func        <= func_s3;
			item_s4.load_hour   <= lh_s3;
			item_s4.load_minute <= lm_s3;
			item_s4.load_second <= ls_s3;
			item_s4.load_mode   <= lmode_s3;
			item_s4.step_hour   <= dh_s3;
			item_s4.step_minute <= dm_full[5:0];
			item_s4.step_second <= ds_full[5:0];
		end
	end

	assign item       = item_s4;
	assign item_valid = valid_s4;

endmodule

@@ hdl/tod_core.sv @@
// ----------------------------------------------------------------------------
// tod_core - time registers and result register
// Applies one operation word per cycle, while res is not stalled, to the
// stored time and registers the result word.
// ----------------------------------------------------------------------------
module tod_core
	import tod_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  split_item_t item,
	input  logic        item_valid,
	output logic        en,
	tod_out_if.source   res
);

	logic [4:0] hour_q;
	logic [5:0] minute_q, second_q;
	logic [1:0] mode_q;

	logic       res_valid_q;
	logic [4:0] res_hour_q;
	logic [5:0] res_minute_q, res_second_q;
	logic [1:0] res_mode_q;
	logic       res_rej_q;

	logic       time_ok;
	logic [4:0] h24;
	logic [6:0] sec_t, min_t;
	logic       sec_c, min_c;
	logic [5:0] sec_n, min_n;
	logic [5:0] hour_t;
	logic [4:0] hour_n;
	logic [4:0] h24_src;
	logic       twelve;
	logic [4:0] nx_hour;
	logic [5:0] nx_minute, nx_second;
	logic [1:0] nx_mode;
	logic       nx_rej;

	assign en = !res_valid_q || res.ready;

	always_comb begin
		time_ok = (minute_q <= MAX_MIN_SEC) && (second_q <= MAX_MIN_SEC);
		if (mode_q == MODE_24)
			time_ok = time_ok && (hour_q <= MAX_HOUR24);
		else if (mode_q == MODE_AM || mode_q == MODE_PM)
			time_ok = time_ok && (hour_q != 5'd0) && (hour_q <= HALF_DAY);
		else
			time_ok = 1'b0;

		if (mode_q == MODE_24)
			h24 = hour_q;
		else if (mode_q == MODE_AM)
			h24 = (hour_q == HALF_DAY) ? 5'd0 : hour_q;
		else
			h24 = (hour_q == HALF_DAY) ? HALF_DAY : hour_q + HALF_DAY;

		// mixed-radix add or subtract, carry/borrow ripples seconds -> hours
		if (item.func == FUNC_RETREAT) begin
			sec_t  = {1'b0, second_q} + SIXTY - {1'b0, item.step_second};
			sec_c  = sec_t < SIXTY;
			sec_n  = sec_c ? sec_t[5:0] : 6'(sec_t - SIXTY);
			min_t  = {1'b0, minute_q} + SIXTY - {1'b0, item.step_minute} - 7'(sec_c);
			min_c  = min_t < SIXTY;
			min_n  = min_c ? min_t[5:0] : 6'(min_t - SIXTY);
			hour_t = {1'b0, h24} + {1'b0, HOURS_PER_DAY} - {1'b0, item.step_hour}
				- 6'(min_c);
		end else begin
			sec_t  = {1'b0, second_q} + {1'b0, item.step_second};
			sec_c  = sec_t >= SIXTY;
			sec_n  = sec_c ? 6'(sec_t - SIXTY) : sec_t[5:0];
			min_t  = {1'b0, minute_q} + {1'b0, item.step_minute} + 7'(sec_c);
			min_c  = min_t >= SIXTY;
			min_n  = min_c ? 6'(min_t - SIXTY) : min_t[5:0];
			hour_t = {1'b0, h24} + {1'b0, item.step_hour} + 6'(min_c);
		end
		hour_n = (hour_t >= {1'b0, HOURS_PER_DAY}) ? 5'(hour_t - {1'b0, HOURS_PER_DAY})
			: hour_t[4:0];

		// convert flips the form, a step keeps it
		if (item.func == FUNC_CONVERT) begin
			h24_src   = h24;
			nx_minute = minute_q;
			nx_second = second_q;
			twelve    = (mode_q == MODE_24);
		end else begin
			h24_src   = hour_n;
			nx_minute = min_n;
			nx_second = sec_n;
			twelve    = (mode_q != MODE_24);
		end

		if (!twelve) begin
			nx_hour = h24_src;
			nx_mode = MODE_24;
		end else if (h24_src == 5'd0) begin
			nx_hour = HALF_DAY;
			nx_mode = MODE_AM;
		end else if (h24_src <= LAST_AM_HOUR) begin
			nx_hour = h24_src;
			nx_mode = MODE_AM;
		end else if (h24_src < FIRST_PM_HOUR) begin
			nx_hour = HALF_DAY;
			nx_mode = MODE_PM;
		end else begin
			nx_hour = h24_src - HALF_DAY;
			nx_mode = MODE_PM;
		end
		nx_rej = 1'b0;

		if (item.func == FUNC_LOAD) begin
			nx_hour   = (item.load_hour <= MAX_HOUR24) ? item.load_hour : 5'd0;
			nx_minute = (item.load_minute <= MAX_MIN_SEC) ? item.load_minute : 6'd0;
			nx_second = (item.load_second <= MAX_MIN_SEC) ? item.load_second : 6'd0;
			nx_mode   = (item.load_mode == MODE_AM || item.load_mode == MODE_PM)
				? item.load_mode : MODE_24;
		end else if (!time_ok) begin
			nx_hour   = hour_q;
			nx_minute = minute_q;
			nx_second = second_q;
			nx_mode   = mode_q;
			nx_rej    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			hour_q      <= 5'd0;
			minute_q    <= 6'd0;
			second_q    <= 6'd0;
			mode_q      <= MODE_24;
		end else if (en) begin
			res_valid_q <= item_valid;
			if (item_valid) begin
				hour_q   <= nx_hour;
				minute_q <= nx_minute;
				second_q <= nx_second;
				mode_q   <= nx_mode;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && item_valid) begin
			res_hour_q   <= nx_hour;
			res_minute_q <= nx_minute;
			res_second_q <= nx_second;
			res_mode_q   <= nx_mode;
			res_rej_q    <= nx_rej;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.cur_hour   = res_hour_q;
	assign res.cur_minute = res_minute_q;
	assign res.cur_second = res_second_q;
	assign res.cur_mode   = res_mode_q;
	assign res.rejected   = res_rej_q;

endmodule

@@ hdl/time_of_day_clock_12_24h.sv @@
// ----------------------------------------------------------------------------
// time_of_day_clock_12_24h - time-of-day clock, 24-hour and 12-hour forms
// Load, advance, retreat and convert operations on a stored h:m:s time.
//
//   channel  dir  word
//   cmd      in   func, load_hour/minute/second/mode, step_count
//   res      out  cur_hour/minute/second/mode, rejected
//
// One word accepted per cycle while res is not stalled. An input register and
// three stages split step_count into h/m/s, then the time registers plus
// result register update from the split word.
// A stall on res freezes the whole pipeline; cmd.ready follows it.
// arst_n clears the time to 00:00:00, 24-hour form, and empties the pipe.
// ----------------------------------------------------------------------------
module time_of_day_clock_12_24h
	import tod_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	tod_in_if.sink    cmd,
	tod_out_if.source res
);

	split_item_t item;
	logic        item_valid;
	logic        en;

	tod_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.cmd        (cmd),
		.item       (item),
		.item_valid (item_valid)
	);

	tod_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.en         (en),
		.res        (res)
	);

endmodule
